[rtl/ctc_pkg.sv]
// Package for the C token classifier: token kind codes, result record type
// and the fixed keyword table with its lookup function. No dependencies.
package ctc_pkg;

  typedef enum logic [2:0] {
    KIND_NUMBER     = 3'd0,
    KIND_KEYWORD    = 3'd1,
    KIND_IDENTIFIER = 3'd2,
    KIND_OPERATOR   = 3'd3,
    KIND_SYMBOL     = 3'd4,
    KIND_LINE_TOTAL = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [4:0]  keyword_index;
    logic [6:0]  token_length;
    logic [7:0]  symbol_char;
    logic [3:0]  digit_value;
    logic [15:0] line_total;
    logic        last_of_run;
  } result_t;

  localparam int KwCount = 32;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = " ";

  // Right-aligned string literals: first character in the highest used byte.
  localparam logic [63:0] KW_STR [KwCount] = '{
    64'("auto"),     64'("break"),   64'("case"),     64'("char"),
    64'("const"),    64'("continue"), 64'("default"), 64'("do"),
    64'("double"),   64'("else"),    64'("enum"),     64'("extern"),
    64'("float"),    64'("for"),     64'("goto"),     64'("if"),
    64'("int"),      64'("long"),    64'("register"), 64'("return"),
    64'("short"),    64'("signed"),  64'("sizeof"),   64'("static"),
    64'("struct"),   64'("switch"),  64'("typedef"),  64'("union"),
    64'("unsigned"), 64'("void"),    64'("volatile"), 64'("while")
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_operator(logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "%") || (c == "/") ||
           (c == "&") || (c == "|") || (c == "=") || (c == "<") || (c == ">");
  endfunction

  // Returns {hit, index}. Prefix holds byte k at bits 8k, zero beyond length.
  function automatic logic [5:0] kw_lookup(logic [63:0] prefix, logic [6:0] len);
    logic [5:0]  res;
    logic [63:0] kw;
    logic [3:0]  klen;
    logic        eq;
    res = '0;
    for (int j = KwCount - 1; j >= 0; j--) begin
      kw   = KW_STR[j];
      klen = '0;
      for (int b = 0; b < 8; b++) begin
        if (kw[8*b +: 8] != 8'd0) begin
          klen = klen + 4'd1;
        end
      end
      eq = (len == {3'd0, klen});
      for (int p = 0; p < 8; p++) begin
        if (p < int'(klen)) begin
          eq = eq && (prefix[8*p +: 8] == kw[8*(int'(klen) - 1 - p) +: 8]);
        end
      end
      if (eq) begin
        res = {1'b1, 5'(j)};
      end
    end
    return res;
  endfunction

endpackage

[rtl/ctc_if.sv]
// Valid/ready channel interfaces for the C token classifier.
// Depends on ctc_pkg for the kind code type.
interface ctc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface ctc_out_if;
  logic                 valid;
  logic                 ready;
  ctc_pkg::kind_t       token_kind;
  logic [4:0]           keyword_index;
  logic [6:0]           token_length;
  logic [7:0]           symbol_char;
  logic [3:0]           digit_value;
  logic [15:0]          line_total;
  logic                 last_of_run;

  modport source (output valid, output token_kind, output keyword_index,
                  output token_length, output symbol_char, output digit_value,
                  output line_total, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input keyword_index,
                  input token_length, input symbol_char, input digit_value,
                  input line_total, input last_of_run, output ready);
endinterface

[rtl/c_token_classifier.sv]
// C token classifier top level: input register, classifier and result queue.
// Depends on ctc_pkg and the channel interfaces in ctc_if.sv.
//
// One byte is taken per clock while the input is not held off. A byte is
// registered on transfer and classified in the next cycle against the
// identifier state; its zero, one or two results enter an eight-entry result
// queue whose head drives the output. The output delivers one result per
// cycle while out_ch.ready is high, so a byte that closes an identifier and is
// itself a token yields two results. The input is held off while more than
// four results are queued. Keywords are matched by 32 parallel comparators
// against the first eight identifier bytes.
module c_token_classifier #(
  parameter int MAX_ID_LEN = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  ctc_in_if.sink           in_ch,
  ctc_out_if.source        out_ch
);

  localparam int          QDepth  = 8;
  localparam int          QAw     = $clog2(QDepth);
  localparam logic [6:0]  LEN_CAP = (MAX_ID_LEN > 127) ? 7'd127 : 7'(MAX_ID_LEN);

  // input register
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_eot_r;

  // identifier state
  logic [63:0] prefix_r, prefix_nxt;
  logic [6:0]  id_len_r, id_len_nxt;
  logic        in_id_r, in_id_nxt;
  logic [15:0] line_r, line_nxt;

  // result queue
  ctc_pkg::result_t q_mem [QDepth];
  logic [QAw-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAw:0]     count_r, count_nxt;

  logic             accept, pop;
  ctc_pkg::result_t res0, res1, r_flush, r_char;
  logic [1:0]       n_push;
  logic             do_flush, char_res;
  logic [5:0]       kw;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (count_r <= (QAw+1)'(QDepth - 4));
  assign pop          = out_ch.valid && out_ch.ready;

  always_comb begin
    prefix_nxt = prefix_r;
    id_len_nxt = id_len_r;
    in_id_nxt  = in_id_r;
    line_nxt   = line_r;
    do_flush   = 1'b0;
    char_res   = 1'b0;
    kw         = ctc_pkg::kw_lookup(prefix_r, id_len_r);

    r_flush               = '0;
    r_flush.token_kind    = kw[5] ? ctc_pkg::KIND_KEYWORD : ctc_pkg::KIND_IDENTIFIER;
    r_flush.keyword_index = kw[5] ? kw[4:0] : 5'd0;
    r_flush.token_length  = id_len_r;
    r_flush.line_total    = line_r;

    r_char            = '0;
    r_char.line_total = line_r;

    if (in_v_r) begin
      if (in_id_r && !in_eot_r && (ctc_pkg::is_alpha(in_char_r) ||
          ctc_pkg::is_digit(in_char_r) || (in_char_r == ctc_pkg::CH_UNDER))) begin
        for (int k = 0; k < 8; k++) begin
          if (id_len_r == 7'(k)) begin
            prefix_nxt[8*k +: 8] = in_char_r;
          end
        end
        if (id_len_r < LEN_CAP) begin
          id_len_nxt = id_len_r + 7'd1;
        end
      end else begin
        if (in_id_r) begin
          do_flush   = 1'b1;
          in_id_nxt  = 1'b0;
          prefix_nxt = '0;
          id_len_nxt = '0;
        end
        priority if (in_eot_r) begin
          char_res          = 1'b1;
          r_char.token_kind = ctc_pkg::KIND_LINE_TOTAL;
          line_nxt          = 16'd1;
          in_id_nxt         = 1'b0;
          prefix_nxt        = '0;
          id_len_nxt        = '0;
        end else if (ctc_pkg::is_digit(in_char_r)) begin
          char_res           = 1'b1;
          r_char.token_kind  = ctc_pkg::KIND_NUMBER;
          r_char.symbol_char = in_char_r;
          r_char.digit_value = 4'(in_char_r - ctc_pkg::CH_ZERO);
        end else if (ctc_pkg::is_alpha(in_char_r) || (in_char_r == ctc_pkg::CH_UNDER)) begin
          in_id_nxt  = 1'b1;
          prefix_nxt = {56'd0, in_char_r};
          id_len_nxt = 7'd1;
        end else if (ctc_pkg::is_operator(in_char_r)) begin
          char_res           = 1'b1;
          r_char.token_kind  = ctc_pkg::KIND_OPERATOR;
          r_char.symbol_char = in_char_r;
        end else if ((in_char_r == ctc_pkg::CH_SPACE) || (in_char_r == ctc_pkg::CH_TAB)) begin
          line_nxt = line_r;
        end else if (in_char_r == ctc_pkg::CH_NL) begin
          if (line_r != 16'hFFFF) begin
            line_nxt = line_r + 16'd1;
          end
        end else begin
          char_res           = 1'b1;
          r_char.token_kind  = ctc_pkg::KIND_SYMBOL;
          r_char.symbol_char = in_char_r;
        end
      end
    end

    r_flush.last_of_run = !char_res;
    r_char.last_of_run  = 1'b1;
    res0   = do_flush ? r_flush : r_char;
    res1   = r_char;
    n_push = {1'b0, do_flush} + {1'b0, char_res};
    count_nxt = count_r + {{(QAw-1){1'b0}}, n_push} - {{QAw{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      prefix_r <= '0;
      id_len_r <= '0;
      in_id_r  <= 1'b0;
      line_r   <= 16'd1;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      in_v_r   <= accept;
      prefix_r <= prefix_nxt;
      id_len_r <= id_len_nxt;
      in_id_r  <= in_id_nxt;
      line_r   <= line_nxt;
      wr_ptr_r <= wr_ptr_r + QAw'(n_push);
      rd_ptr_r <= rd_ptr_r + QAw'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_char_r <= in_ch.char_code;
      in_eot_r  <= in_ch.end_of_text;
    end
    if (n_push != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_mem[wr_ptr_r + QAw'(1)] <= res1;
    end
  end

  assign out_ch.valid         = (count_r != '0);
  assign out_ch.token_kind    = q_mem[rd_ptr_r].token_kind;
  assign out_ch.keyword_index = q_mem[rd_ptr_r].keyword_index;
  assign out_ch.token_length  = q_mem[rd_ptr_r].token_length;
  assign out_ch.symbol_char   = q_mem[rd_ptr_r].symbol_char;
  assign out_ch.digit_value   = q_mem[rd_ptr_r].digit_value;
  assign out_ch.line_total    = q_mem[rd_ptr_r].line_total;
  assign out_ch.last_of_run   = q_mem[rd_ptr_r].last_of_run;

endmodule
